// File: hw/rtl/ssif_pkg.sv
// ============================================================================
// ssif_pkg - shared types and constants for the safety stop input filter
// Register indexes, reset values, field widths and the control and
// configuration bundles passed between the filter modules.
// ============================================================================
package ssif_pkg;

    // Field widths
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 56;
    localparam int unsigned M_DATA_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ESTOP_RELEASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEALTH_HYST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STOP_DISTANCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLEAR_DISTANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENGAGE_HOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OBSTACLE_RELEASE = 3'd5;

    // Configuration reset values
    localparam logic [COUNT_W-1:0] RST_ESTOP_RELEASE    = 8'd3;
    localparam logic [COUNT_W-1:0] RST_HEALTH_HYST      = 8'd3;
    localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE    = 16'd500;
    localparam logic [DIST_W-1:0]  RST_CLEAR_DISTANCE   = 16'd700;
    localparam logic [HOLD_W-1:0]  RST_ENGAGE_HOLD      = 16'd100;
    localparam logic [COUNT_W-1:0] RST_OBSTACLE_RELEASE = 8'd3;

    // Input command codes
    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // Configuration register set
    typedef struct packed {
        logic [COUNT_W-1:0] estop_release_count;
        logic [COUNT_W-1:0] health_hysteresis_count;
        logic [DIST_W-1:0]  stop_distance_mm;
        logic [DIST_W-1:0]  clear_distance_mm;
        logic [HOLD_W-1:0]  hold_time_ms;
        logic [COUNT_W-1:0] obstacle_release_count;
    } cfg_t;

    // Per-transaction control to the filter state
    typedef struct packed {
        logic step;   // poll transaction leaves the input register
        logic clear;  // reset command leaves the input register
    } ctl_t;

endpackage

// File: hw/rtl/ssif_stop_latch.sv
// ============================================================================
// ssif_stop_latch - emergency stop latch with release count
// Sets at once on an active poll; clears after a run of inactive polls.
// ============================================================================
module ssif_stop_latch (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ssif_pkg::ctl_t               ctl,
    input  logic                         active,
    input  logic [ssif_pkg::COUNT_W-1:0] release_count,
    output logic                         stop
);

    logic [ssif_pkg::COUNT_W-1:0] count_reg;
    logic [ssif_pkg::COUNT_W-1:0] count_next;
    logic                         latched_reg;
    logic                         latched_next;

    // Set on active, otherwise count inactive polls towards release
    always_comb begin
        count_next   = count_reg;
        latched_next = latched_reg;
        if (active) begin
            latched_next = 1'b1;
            count_next   = '0;
        end else begin
            if (count_reg < release_count) begin
                count_next = count_reg + 1'b1;
            end
            if (count_next >= release_count) begin
                latched_next = 1'b0;
            end
        end
    end

    assign stop = latched_next;

    // Advance on each poll transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            latched_reg <= 1'b0;
        end else if (ctl.step) begin
            count_reg   <= count_next;
            latched_reg <= latched_next;
        end
    end

endmodule

// File: hw/rtl/ssif_health_filter.sv
// ============================================================================
// ssif_health_filter - hysteresis filter on ultrasonic health
// First poll after a clear is taken as is; later changes need a run of
// differing polls.
// ============================================================================
module ssif_health_filter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ssif_pkg::ctl_t               ctl,
    input  logic                         raw_ok,
    input  logic [ssif_pkg::COUNT_W-1:0] hysteresis_count,
    output logic                         healthy
);

    logic                         prev_reg;
    logic                         prev_next;
    logic                         seen_reg;
    logic                         seen_next;
    logic [ssif_pkg::COUNT_W-1:0] count_reg;
    logic [ssif_pkg::COUNT_W-1:0] count_next;
    logic [ssif_pkg::COUNT_W-1:0] count_inc;

    assign count_inc = count_reg + 1'b1;

    // Take the first poll, then count differing polls
    always_comb begin
        prev_next  = prev_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        if (!seen_reg) begin
            prev_next  = raw_ok;
            seen_next  = 1'b1;
            count_next = '0;
        end else if (raw_ok != prev_reg) begin
            if (count_inc >= hysteresis_count) begin
                prev_next  = raw_ok;
                count_next = '0;
            end else begin
                count_next = count_inc;
            end
        end else begin
            count_next = '0;
        end
    end

    assign healthy = prev_next;

    // Clear on reset command, advance on poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            count_reg <= '0;
        end else if (ctl.clear) begin
            prev_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            count_reg <= '0;
        end else if (ctl.step) begin
            prev_reg  <= prev_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/ssif_near_filter.sv
// ============================================================================
// ssif_near_filter - obstacle near flag with engage hold and release count
// Compares distance against the stop or clear threshold, latches after the
// hold time and releases after a run of clear polls.
// ============================================================================
module ssif_near_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ssif_pkg::ctl_t              ctl,
    input  ssif_pkg::cfg_t              cfg,
    input  logic                        sensor_ready,
    input  logic [ssif_pkg::DIST_W-1:0] distance_mm,
    input  logic [ssif_pkg::TIME_W-1:0] time_ms,
    output logic                        near
);

    logic [ssif_pkg::HOLD_W-1:0]  hold_copy_reg;
    logic [ssif_pkg::COUNT_W-1:0] release_copy_reg;
    logic [ssif_pkg::TIME_W-1:0]  since_reg;
    logic [ssif_pkg::TIME_W-1:0]  since_next;
    logic                         pending_reg;
    logic                         pending_next;
    logic [ssif_pkg::COUNT_W-1:0] clear_count_reg;
    logic [ssif_pkg::COUNT_W-1:0] clear_count_next;
    logic                         latched_reg;
    logic                         latched_next;
    logic [ssif_pkg::DIST_W-1:0]  threshold;
    logic                         close;
    logic [ssif_pkg::TIME_W-1:0]  elapsed;

    // Pick the threshold by the current flag
    assign threshold = latched_reg ? cfg.clear_distance_mm : cfg.stop_distance_mm;
    assign close     = sensor_ready && (distance_mm < threshold);

    // Start time is this poll when a too-close run begins
    assign since_next = (close && !latched_reg && !pending_reg) ? time_ms : since_reg;
    assign elapsed    = time_ms - since_next;

    // Engage after hold, release after clear polls
    always_comb begin
        pending_next     = pending_reg;
        clear_count_next = clear_count_reg;
        latched_next     = latched_reg;
        if (close) begin
            clear_count_next = '0;
            if (!latched_reg) begin
                pending_next = 1'b1;
                if (elapsed >= {{(ssif_pkg::TIME_W-ssif_pkg::HOLD_W){1'b0}}, hold_copy_reg})
                begin
                    latched_next = 1'b1;
                    pending_next = 1'b0;
                end
            end
        end else begin
            pending_next = 1'b0;
            if (latched_reg) begin
                if (clear_count_reg < release_copy_reg) begin
                    clear_count_next = clear_count_reg + 1'b1;
                end
                if (clear_count_next >= release_copy_reg) begin
                    latched_next     = 1'b0;
                    clear_count_next = '0;
                end
            end else begin
                clear_count_next = '0;
            end
        end
    end

    assign near = latched_next;

    // Reload the timing copies on reset command, advance on poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_copy_reg    <= ssif_pkg::RST_ENGAGE_HOLD;
            release_copy_reg <= ssif_pkg::RST_OBSTACLE_RELEASE;
            since_reg        <= '0;
            pending_reg      <= 1'b0;
            clear_count_reg  <= '0;
            latched_reg      <= 1'b0;
        end else if (ctl.clear) begin
            hold_copy_reg    <= cfg.hold_time_ms;
            release_copy_reg <= cfg.obstacle_release_count;
            since_reg        <= '0;
            pending_reg      <= 1'b0;
            clear_count_reg  <= '0;
            latched_reg      <= 1'b0;
        end else if (ctl.step) begin
            since_reg       <= since_next;
            pending_reg     <= pending_next;
            clear_count_reg <= clear_count_next;
            latched_reg     <= latched_next;
        end
    end

endmodule

// File: hw/rtl/safety_stop_input_filter.sv
// ============================================================================
// safety_stop_input_filter - qualifies stop inputs, sensor health and obstacle
// Input register, filter logic and result register; one poll per transaction.
// ============================================================================
// A poll passes the input register, then the result register, to m_tdata; it
// waits in the input register while the result side is not free. The filter
// state updates as a transaction leaves; up to one transaction per cycle.
// A reset command consumes one transaction, clears the ultrasonic filters and
// gives no result. aresetn clears all filter state and loads register defaults.
module safety_stop_input_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [ssif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssif_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] button_ready, [1] button_raw_active, [2] remote_ready,
    // [3] remote_raw_active, [4] sensor_ready, [5] sensor health flag,
    // [21:6] distance_mm, [53:22] time_ms, [55:54] zero
    input  logic [ssif_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                            s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] button_stop, [1] remote_stop, [2] sensor_healthy,
    // [3] obstacle_near, [7:4] zero
    output logic [ssif_pkg::M_DATA_W-1:0]   m_tdata
);

    ssif_pkg::cfg_t                cfg_reg;
    logic                          in_valid_reg;
    logic                          in_cmd_reg;
    logic [ssif_pkg::S_DATA_W-1:0] in_data_reg;
    logic                          out_valid_reg;
    logic [ssif_pkg::M_DATA_W-1:0] out_data_reg;
    logic                          advance;
    ssif_pkg::ctl_t                ctl;
    logic                          button_active;
    logic                          remote_active;
    logic                          sensor_ready;
    logic                          button_stop;
    logic                          remote_stop;
    logic                          sensor_healthy;
    logic                          obstacle_near;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.estop_release_count     <= ssif_pkg::RST_ESTOP_RELEASE;
            cfg_reg.health_hysteresis_count <= ssif_pkg::RST_HEALTH_HYST;
            cfg_reg.stop_distance_mm        <= ssif_pkg::RST_STOP_DISTANCE;
            cfg_reg.clear_distance_mm       <= ssif_pkg::RST_CLEAR_DISTANCE;
            cfg_reg.hold_time_ms            <= ssif_pkg::RST_ENGAGE_HOLD;
            cfg_reg.obstacle_release_count  <= ssif_pkg::RST_OBSTACLE_RELEASE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ssif_pkg::CFG_IDX_ESTOP_RELEASE:
                    cfg_reg.estop_release_count <= cfg_wdata[ssif_pkg::COUNT_W-1:0];
                ssif_pkg::CFG_IDX_HEALTH_HYST:
                    cfg_reg.health_hysteresis_count <= cfg_wdata[ssif_pkg::COUNT_W-1:0];
                ssif_pkg::CFG_IDX_STOP_DISTANCE:
                    cfg_reg.stop_distance_mm <= cfg_wdata[ssif_pkg::DIST_W-1:0];
                ssif_pkg::CFG_IDX_CLEAR_DISTANCE:
                    cfg_reg.clear_distance_mm <= cfg_wdata[ssif_pkg::DIST_W-1:0];
                ssif_pkg::CFG_IDX_ENGAGE_HOLD:
                    cfg_reg.hold_time_ms <= cfg_wdata[ssif_pkg::HOLD_W-1:0];
                ssif_pkg::CFG_IDX_OBSTACLE_RELEASE:
                    cfg_reg.obstacle_release_count <= cfg_wdata[ssif_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A reset command leaves without a result; a poll needs a free result slot
    assign advance  = in_valid_reg &&
                      ((in_cmd_reg == ssif_pkg::CMD_RESET) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign ctl.step  = advance && (in_cmd_reg == ssif_pkg::CMD_POLL);
    assign ctl.clear = advance && (in_cmd_reg == ssif_pkg::CMD_RESET);

    // Hold the accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Unready sources count as active
    assign button_active = !in_data_reg[0] || in_data_reg[1];
    assign remote_active = !in_data_reg[2] || in_data_reg[3];
    assign sensor_ready  = in_data_reg[4];

    ssif_stop_latch u_button_latch (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .active        (button_active),
        .release_count (cfg_reg.estop_release_count),
        .stop          (button_stop)
    );

    ssif_stop_latch u_remote_latch (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .active        (remote_active),
        .release_count (cfg_reg.estop_release_count),
        .stop          (remote_stop)
    );

    ssif_health_filter u_health (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .raw_ok           (sensor_ready && in_data_reg[5]),
        .hysteresis_count (cfg_reg.health_hysteresis_count),
        .healthy          (sensor_healthy)
    );

    ssif_near_filter u_near (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .cfg          (cfg_reg),
        .sensor_ready (sensor_ready),
        .distance_mm  (in_data_reg[21:6]),
        .time_ms      (in_data_reg[53:22]),
        .near         (obstacle_near)
    );

    // Result register: load on poll, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            out_data_reg <= {4'b0000, obstacle_near, sensor_healthy, remote_stop, button_stop};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
